// File: rtl/ned_pkg.sv
// Shared types and constants for the name escape decoder.
`default_nettype none

package ned_pkg;

  localparam int unsigned HoldMax    = 5;
  localparam int unsigned SlotCount  = HoldMax + 1;
  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] EscLead   = 8'h5F;  // '_'
  localparam logic [7:0] EscMark   = 8'h5A;  // 'Z'
  localparam logic [7:0] DigitZero = 8'h30;  // '0'
  localparam logic [7:0] DigitNine = 8'h39;  // '9'

  localparam logic [9:0] EscLimit  = 10'd256;

  // One unit of work for the back end: up to six bytes to send in order.
  typedef struct packed {
    logic [SlotCount-1:0][7:0] bytes;
    logic [2:0]                cnt;   // number of valid slots, 1..6
    logic                      last;  // final slot closes the name
    logic                      any;   // an escape was replaced in this name
  } ned_rec_t;

endpackage

`default_nettype wire

// File: rtl/ned_front.sv
// Front end: matches escapes, holds partial matches, emits byte groups.
`default_nettype none

module ned_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       in_byte_i,
  input  wire logic             in_last_i,
  output logic                  rec_valid_o,
  input  wire logic             rec_ready_i,
  output ned_pkg::ned_rec_t     rec_o
);

  logic [ned_pkg::HoldMax-1:0][7:0] held_q, held_d;
  logic [2:0]                       count_q, count_d;
  logic                             seen_q, seen_d;

  logic       accept;
  logic       is_lead, is_digit, fits, esc_hit;
  logic [9:0] esc_val;
  logic [2:0] n_out;

  assign in_ready_o = rec_ready_i;
  assign accept     = in_valid_i & rec_ready_i;

  assign is_lead  = (in_byte_i == ned_pkg::EscLead);
  assign is_digit = (in_byte_i >= ned_pkg::DigitZero) && (in_byte_i <= ned_pkg::DigitNine);

  // Held digits are known to be '0'..'9', so the low nibble is the digit.
  assign esc_val = {6'd0, held_q[2][3:0]} * 10'd100
                 + {6'd0, held_q[3][3:0]} * 10'd10
                 + {6'd0, held_q[4][3:0]};

  always_comb begin
    unique case (count_q)
      3'd0:                fits = is_lead;
      3'd1:                fits = (in_byte_i == ned_pkg::EscMark);
      3'd2, 3'd3, 3'd4:    fits = is_digit;
      default:             fits = 1'b0;
    endcase
  end

  assign esc_hit = (count_q == 3'd5) && is_lead && (esc_val < ned_pkg::EscLimit);

  always_comb begin
    held_d  = held_q;
    count_d = count_q;
    seen_d  = seen_q;
    n_out   = 3'd0;
    rec_o   = '0;

    // Held bytes first, then the incoming byte in the next slot.
    for (int i = 0; i < ned_pkg::HoldMax; i++) begin
      if (3'(i) < count_q) begin
        rec_o.bytes[i] = held_q[i];
      end else begin
        rec_o.bytes[i] = in_byte_i;
      end
    end
    rec_o.bytes[ned_pkg::HoldMax] = in_byte_i;

    priority if (esc_hit) begin
      rec_o.bytes[0] = esc_val[7:0];
      n_out   = 3'd1;
      count_d = 3'd0;
      seen_d  = 1'b1;
    end else if (in_last_i) begin
      n_out = count_q + 3'd1;
    end else if (fits) begin
      held_d[count_q] = in_byte_i;
      count_d = count_q + 3'd1;
    end else if (is_lead) begin
      n_out     = count_q;
      held_d[0] = in_byte_i;
      count_d   = 3'd1;
    end else begin
      n_out   = count_q + 3'd1;
      count_d = 3'd0;
    end

    if (in_last_i) begin
      rec_o.any = seen_q | esc_hit;
      count_d   = 3'd0;
      seen_d    = 1'b0;
    end
    rec_o.cnt  = n_out;
    rec_o.last = in_last_i;

    if (!accept) begin
      held_d  = held_q;
      count_d = count_q;
      seen_d  = seen_q;
    end
  end

  assign rec_valid_o = in_valid_i & (n_out != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
      seen_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

`default_nettype wire

// File: rtl/ned_fifo.sv
// Short queue of byte groups between front end and back end.
`default_nettype none

module ned_fifo #(
  parameter int unsigned Depth = ned_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   ready_o,
  input  wire ned_pkg::ned_rec_t data_i,
  output logic                   valid_o,
  input  wire logic              pop_i,
  output ned_pkg::ned_rec_t      data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ned_pkg::ned_rec_t mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic              do_push, do_pop;

  assign ready_o = (fill_q != CntW'(Depth));
  assign valid_o = (fill_q != '0);
  assign data_o  = mem_q[rd_q];

  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   fill_d = fill_q + CntW'(1);
      2'b01:   fill_d = fill_q - CntW'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ned_back.sv
// Back end: sends the bytes of each group one transfer at a time.
`default_nettype none

module ned_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rec_valid_i,
  output logic                   rec_pop_o,
  input  wire ned_pkg::ned_rec_t rec_i,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [7:0]             m_axis_tdata,
  output logic                   m_axis_tlast,
  output logic                   m_axis_tuser
);

  ned_pkg::ned_rec_t rec_q, rec_d;
  logic [2:0]        idx_q, idx_d;
  logic              busy_q, busy_d;
  logic              final_slot, advance, done, load;

  assign final_slot = (idx_q == rec_q.cnt - 3'd1);
  assign advance    = busy_q & m_axis_tready;
  assign done       = advance & final_slot;
  assign load       = (~busy_q | done) & rec_valid_i;
  assign rec_pop_o  = load;

  always_comb begin
    rec_d  = rec_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    if (load) begin
      rec_d  = rec_i;
      idx_d  = 3'd0;
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (advance) begin
      idx_d = idx_q + 3'd1;
    end
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = rec_q.bytes[idx_q];
  assign m_axis_tlast  = rec_q.last & final_slot;
  assign m_axis_tuser  = rec_q.any & rec_q.last & final_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

endmodule

`default_nettype wire

// File: rtl/name_escape_decoder.sv
// Path: decoded bytes pass through the queue, then the back-end register.
// Throughput: one input transfer per cycle while the queue has room; the back
//   end sends one output transfer per cycle while the sink is ready; a group
//   has up to six bytes (a released partial escape plus the current byte).
// Reset: asynchronous, active low; clears match state, queue and output stage.
// Held escape bytes are not reset; they are only read once written.
`default_nettype none

module name_escape_decoder #(
  parameter int unsigned QueueDepth = ned_pkg::QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Input stream
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,   // in_last
  // Output stream
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast,   // out_last
  output logic            m_axis_tuser    // [0] any_decoded
);

  // Front end to queue
  ned_pkg::ned_rec_t front_rec;
  logic              front_valid;
  logic              queue_ready;

  // Queue to back end
  ned_pkg::ned_rec_t queue_rec;
  logic              queue_valid;
  logic              back_pop;

  // Match the escape pattern and turn each input transfer into a byte group.
  // A transfer that only extends a partial match yields no group.
  ned_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .rec_valid_o (front_valid),
    .rec_ready_i (queue_ready),
    .rec_o       (front_rec)
  );

  // Decouple matching from sending so a stalled sink does not stop the
  // front end until the queue fills.
  ned_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .ready_o (queue_ready),
    .data_i  (front_rec),
    .valid_o (queue_valid),
    .pop_i   (back_pop),
    .data_o  (queue_rec)
  );

  // Serialise each group; the next group loads on the final transfer.
  ned_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_valid_i   (queue_valid),
    .rec_pop_o     (back_pop),
    .rec_i         (queue_rec),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// File: rtl/ned_checker.sv
// Port-level checks for the name escape decoder, bound to the top level.
`default_nettype none

module ned_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       s_axis_tlast,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast,
  input wire logic       m_axis_tuser
);

  logic        in_xfer, out_xfer;
  logic [15:0] byte_bal_q;
  logic [7:0]  name_bal_q;

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign out_xfer = m_axis_tvalid & m_axis_tready;

  // Track bytes and names taken in but not yet matched by output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_bal_q <= '0;
      name_bal_q <= '0;
    end else begin
      byte_bal_q <= byte_bal_q + 16'(in_xfer) - 16'(out_xfer);
      name_bal_q <= name_bal_q + 8'(in_xfer & s_axis_tlast)
                                - 8'(out_xfer & m_axis_tlast);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transfer changed while stalled");

  a_flag_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("decode flag set away from the end of a name");

  a_no_extra_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> byte_bal_q != 16'd0)
    else $error("more bytes sent than received");

  a_no_extra_names: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && m_axis_tlast |-> name_bal_q != 8'd0)
    else $error("name closed on output before it was closed on input");

endmodule

bind name_escape_decoder ned_checker u_ned_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: tb/sv/tb_name_escape_decoder.sv
// Self-checking testbench for the name escape decoder: directed table plus random names.
`default_nettype none

module tb_name_escape_decoder;

  localparam int unsigned DirCount    = 24;
  localparam int unsigned RandomItems = 446;
  localparam int unsigned StallLimit  = 1000;  // idle cycles before the watchdog trips
  localparam int unsigned DrainCycles = 20;    // settle time after the last expected byte

  // One decoded byte as it should leave the output stream.
  typedef struct packed {
    logic [7:0] data;
    logic       fin;   // out_last
    logic       hit;   // any_decoded
  } dec_byte_t;

  // One row of the directed table; typed rows carry their single expected byte.
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       typed;
    logic [7:0] want_data;
    logic       want_hit;
  } dir_row_t;

  typedef enum logic [1:0] {SinkOpen, SinkCoin, SinkComb, SinkStarve} sink_mode_e;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] in_byte
  logic       s_axis_tlast  = 1'b0;   // in_last
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic       m_axis_tlast;           // out_last
  logic       m_axis_tuser;           // [0] any_decoded

  // Decoder model state: held escape bytes, their count, escape seen in this name.
  logic [7:0] esc_buf [ned_pkg::HoldMax];
  int unsigned esc_len  = 0;
  logic        name_hit = 1'b0;

  dec_byte_t step_bytes [$];  // bytes caused by the current input transfer
  dec_byte_t decoded_q  [$];  // bytes still owed by the decoder, oldest first
  dec_byte_t want;
  logic [7:0] name_q    [$];  // random name being sent

  int unsigned mismatch_cnt = 0;
  int unsigned burst_left   = 0;
  int unsigned gap          = 0;
  int unsigned stall_run    = 0;
  int unsigned sink_left    = 0;
  int unsigned cyc_cnt      = 0;
  sink_mode_e  sink_mode    = SinkOpen;

  // Directed names: extremes, a full escape, a too-large value, broken candidates.
  dir_row_t dir_rows [DirCount] = '{
    '{8'h00,             1'b1, 1'b1, 8'h00, 1'b0},  // lowest byte, one-byte name
    '{8'hFF,             1'b1, 1'b1, 8'hFF, 1'b0},  // highest byte, one-byte name
    '{ned_pkg::EscLead,  1'b0, 1'b0, 8'h00, 1'b0},  // escape of the largest legal value
    '{ned_pkg::EscMark,  1'b0, 1'b0, 8'h00, 1'b0},
    '{"2",               1'b0, 1'b0, 8'h00, 1'b0},
    '{"5",               1'b0, 1'b0, 8'h00, 1'b0},
    '{"5",               1'b0, 1'b0, 8'h00, 1'b0},
    '{ned_pkg::EscLead,  1'b1, 1'b1, 8'hFF, 1'b1},
    '{ned_pkg::EscLead,  1'b0, 1'b0, 8'h00, 1'b0},  // value too large: closing lead restarts
    '{ned_pkg::EscMark,  1'b0, 1'b0, 8'h00, 1'b0},
    '{"2",               1'b0, 1'b0, 8'h00, 1'b0},
    '{"5",               1'b0, 1'b0, 8'h00, 1'b0},
    '{"6",               1'b0, 1'b0, 8'h00, 1'b0},
    '{ned_pkg::EscLead,  1'b1, 1'b0, 8'h00, 1'b0},
    '{ned_pkg::EscLead,  1'b0, 1'b0, 8'h00, 1'b0},  // second lead breaks and restarts
    '{ned_pkg::EscLead,  1'b0, 1'b0, 8'h00, 1'b0},
    '{ned_pkg::EscMark,  1'b0, 1'b0, 8'h00, 1'b0},
    '{"0",               1'b0, 1'b0, 8'h00, 1'b0},
    '{"/",               1'b0, 1'b0, 8'h00, 1'b0},  // just below the digits
    '{ned_pkg::EscLead,  1'b0, 1'b0, 8'h00, 1'b0},
    '{ned_pkg::EscMark,  1'b0, 1'b0, 8'h00, 1'b0},
    '{"9",               1'b0, 1'b0, 8'h00, 1'b0},
    '{":",               1'b0, 1'b0, 8'h00, 1'b0},  // just above the digits
    '{ned_pkg::EscLead,  1'b1, 1'b0, 8'h00, 1'b0}   // name ends on a held lead
  };

  name_escape_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Print one line per mismatch and count every one.
  task automatic report_mismatch(input string what, input int got, input int exp_val);
    mismatch_cnt++;
    $display("mismatch: %s got %0h want %0h at %0t", what, got, exp_val, $time);
  endtask

  function automatic void emit_byte(input logic [7:0] b);
    step_bytes.insert(step_bytes.size(), '{b, 1'b0, 1'b0});
  endfunction

  // Flush the held partial escape in arrival order.
  function automatic void flush_held();
    for (int i = 0; i < esc_len; i++) begin
      emit_byte(esc_buf[i]);
    end
    esc_len = 0;
  endfunction

  // Advance the decoder model by one input byte; fills step_bytes.
  function automatic void decode_step(input logic [7:0] b, input logic fin);
    int unsigned pos;
    int          val;
    logic        fits;
    pos  = esc_len;
    fits = 1'b0;
    step_bytes.delete();
    if (pos == 0) begin
      fits = (b == ned_pkg::EscLead);
    end else if (pos == 1) begin
      fits = (b == ned_pkg::EscMark);
    end else if (pos <= 4) begin
      fits = (b >= ned_pkg::DigitZero) && (b <= ned_pkg::DigitNine);
    end else begin
      // Five bytes held: only a closing lead with a value below the limit completes.
      val = (int'(esc_buf[2]) - int'(ned_pkg::DigitZero)) * 100
          + (int'(esc_buf[3]) - int'(ned_pkg::DigitZero)) * 10
          + (int'(esc_buf[4]) - int'(ned_pkg::DigitZero));
      if (b == ned_pkg::EscLead && val < int'(ned_pkg::EscLimit)) begin
        emit_byte(8'(val));
        esc_len  = 0;
        name_hit = 1'b1;
        pos      = ned_pkg::SlotCount;
      end
    end
    if (pos <= ned_pkg::HoldMax) begin
      if (fits) begin
        esc_buf[pos] = b;
        esc_len      = pos + 1;
      end else begin
        // Mismatch: release what is held, then restart on a lead or pass the byte.
        flush_held();
        if (b == ned_pkg::EscLead) begin
          esc_buf[0] = b;
          esc_len    = 1;
        end else begin
          emit_byte(b);
        end
      end
    end
    if (fin) begin
      flush_held();
      step_bytes[step_bytes.size()-1].fin = 1'b1;
      step_bytes[step_bytes.size()-1].hit = name_hit;
      name_hit = 1'b0;
    end
  endfunction

  // Append the first keep bytes of the escape form of value v.
  function automatic void push_escape(input int unsigned v, input int unsigned keep);
    logic [7:0] form [ned_pkg::SlotCount];
    form[0] = ned_pkg::EscLead;
    form[1] = ned_pkg::EscMark;
    form[2] = ned_pkg::DigitZero + 8'(v / 100);
    form[3] = ned_pkg::DigitZero + 8'((v / 10) % 10);
    form[4] = ned_pkg::DigitZero + 8'(v % 10);
    form[5] = ned_pkg::EscLead;
    for (int i = 0; i < keep; i++) begin
      name_q.insert(name_q.size(), form[i]);
    end
  endfunction

  // Offer one byte in bursts with random gaps; on acceptance log the owed bytes.
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input logic [7:0] t_data, input logic t_hit);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_step(b, fin);
    if (typed) begin
      decoded_q.insert(decoded_q.size(), '{t_data, 1'b1, t_hit});
    end else begin
      foreach (step_bytes[i]) decoded_q.insert(decoded_q.size(), step_bytes[i]);
    end
  endtask

  // Hold off the sender until the decoder owes nothing.
  task automatic drain_pause();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (decoded_q.size() != 0);
  endtask

  // Receiver: switch between stall patterns for random stretches.
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_left = $urandom_range(16, 200);
    end else begin
      sink_left--;
    end
    case (sink_mode)
      SinkOpen:  m_axis_tready <= 1'b1;
      SinkCoin:  m_axis_tready <= 1'($urandom_range(0, 1));
      SinkComb:  m_axis_tready <= (cyc_cnt % 4 != 3);
      default:   m_axis_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Check each output transfer against the oldest owed byte.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("byte with nothing owed", m_axis_tdata, 0);
      end else begin
        want = decoded_q.pop_front();
        if (m_axis_tdata !== want.data) report_mismatch("out_byte", m_axis_tdata, want.data);
        if (m_axis_tlast !== want.fin)  report_mismatch("out_last", m_axis_tlast, want.fin);
        if (m_axis_tuser !== want.hit)  report_mismatch("any_decoded", m_axis_tuser, want.hit);
      end
    end
  end

  // Watchdog: end the run after too many cycles without a transfer.
  initial begin
    while (stall_run < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_run = 0;
      end else begin
        stall_run++;
      end
    end
    $display("[name_escape_decoder] ERROR");
    $finish;
  end

  // Stimulus: reset, directed table, then random names.
  initial begin
    int unsigned sent;
    int unsigned segs;
    logic        paused;
    sent   = 0;
    paused = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].fin, dir_rows[i].typed,
                dir_rows[i].want_data, dir_rows[i].want_hit);
    end
    drain_pause();

    while (sent < RandomItems) begin
      name_q.delete();
      segs = $urandom_range(1, 5);
      for (int s = 0; s < segs; s++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            repeat ($urandom_range(1, 3)) begin
              name_q.insert(name_q.size(), 8'($urandom_range(0, 255)));
            end
          end
          3, 4, 5: push_escape($urandom_range(0, 255), ned_pkg::SlotCount);
          6:       push_escape($urandom_range(256, 999), ned_pkg::SlotCount);
          7, 8: begin
            // Broken candidate: cut short, then usually followed by a near-miss or random byte.
            push_escape($urandom_range(0, 999), $urandom_range(1, ned_pkg::HoldMax));
            case ($urandom_range(0, 6))
              0: name_q.insert(name_q.size(), 8'($urandom_range(0, 255)));
              1: name_q.insert(name_q.size(), ned_pkg::EscLead);
              2: name_q.insert(name_q.size(), ned_pkg::EscMark);
              3: name_q.insert(name_q.size(), ned_pkg::DigitZero - 8'd1);
              4: name_q.insert(name_q.size(), ned_pkg::DigitNine + 8'd1);
              5: name_q.insert(name_q.size(),
                               ned_pkg::DigitZero + 8'($urandom_range(0, 9)));
              default: ;
            endcase
          end
          default: begin
            case ($urandom_range(0, 2))
              0: name_q.insert(name_q.size(), ned_pkg::EscLead);
              1: name_q.insert(name_q.size(), ned_pkg::EscMark);
              default: name_q.insert(name_q.size(),
                                     ned_pkg::DigitZero + 8'($urandom_range(0, 9)));
            endcase
          end
        endcase
      end
      // Drain once midway so the decoder restarts from an empty pipe.
      if (!paused && sent >= RandomItems / 2) begin
        drain_pause();
        paused = 1'b1;
      end
      for (int k = 0; k < name_q.size(); k++) begin
        send_byte(name_q[k], k == name_q.size() - 1, 1'b0, 8'h00, 1'b0);
      end
      sent += name_q.size();
    end

    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      report_mismatch("bytes never delivered", 0, decoded_q.size());
    end
    if (mismatch_cnt == 0) begin
      $display("[name_escape_decoder] OK");
    end else begin
      $display("[name_escape_decoder] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
